FILE: design/selective_repeat_receive_window_macros.svh
// Assertion macros for the selective-repeat receive window.
// Needs nothing else; included by the modules that carry assertions.
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRRW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/srrw_pkg.sv
// Shared types, codes and command/status structs of the receive window.
// No dependencies; imported by every module of the block.
`default_nettype none

package srrw_pkg;

   // Sequence space and window geometry (window must be a power of two)
   localparam int SEQ_W       = 8;
   localparam int SEQ_MODULUS = 256;
   localparam int WINDOW      = 16;
   localparam int IDX_W       = 4;
   localparam int TAG_W       = 32;
   localparam int CNT_W       = 5;
   localparam int KIND_W      = 3;
   localparam int CFG_W       = 8;

   typedef logic [SEQ_W-1:0]  seq_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [TAG_W-1:0]  tag_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [CFG_W-1:0]  cfg_type;
   typedef logic              csr_idx_type;

   // Result kinds
   localparam kind_type KIND_DELIVERY = 3'd0;
   localparam kind_type KIND_ACK_HDR  = 3'd1;
   localparam kind_type KIND_NACK     = 3'd2;
   localparam kind_type KIND_READY    = 3'd3;
   localparam kind_type KIND_FINISHED = 3'd4;

   // Configuration register indexes
   localparam csr_idx_type CSR_BURST_SIZE  = 1'b0;
   localparam csr_idx_type CSR_BURST_TICKS = 1'b1;

   // Reset values of the configuration registers
   localparam cfg_type BURST_SIZE_RST  = 8'd25;
   localparam cfg_type BURST_TICKS_RST = 8'd1;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_DATA   = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_FINISH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      RK_READY    = 2'd0,
      RK_ACK      = 2'd1,
      RK_FINISHED = 2'd2
   } resp_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_EMIT_SIMPLE,
      S_DRAIN_RD,
      S_DRAIN_OUT,
      S_POST_DATA,
      S_ACK_INIT,
      S_ACK_COUNT,
      S_ACK_HDR,
      S_ACK_NACK
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic do_start;
      logic do_finish;
      logic do_tick;
      logic do_store;
      logic tag_rd;
      logic deliver;
      logic post_data;
      logic scan_init;
      logic scan_count;
      logic emit_hdr;
      logic scan_nack;
      logic emit_simple;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type    action;
      logic          item_ok;
      logic          at_start;
      logic          next_used;
      logic          send;
      logic          in_progress;
      resp_kind_type last_kind;
      logic          scan_done;
      logic          scan_miss;
      logic          cnt_zero;
      logic          remaining_one;
      logic          out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: design/selective_repeat_receive_window.sv
// Channel   Handshake              Word
// req       req_valid/req_ready    action, seq_num, payload_tag
// rsp       rsp_valid/rsp_ready    kind, seq_out, tag_out, cumulative_ack,
//                                  nack_count, resp_seq, last
// csr       csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One item at a time: start, finish and a resent ready pass through decode and the emit
// state, a tick with nothing to resend through decode only; a data packet adds a tag read,
// then an output, per delivered slot. An ack adds a count pass, then a nack pass, over the
// scanned sequences, one slot per cycle; a nack waiting on a full output stalls the scan.
// Synchronous active-high reset; no clearing pass. A stalled rsp side holds the sequencer
// at its next word; req_ready rises once the item's last word sits in the output register.
// Depends on srrw_pkg, srrw_ctrl and srrw_datapath.
`default_nettype none

module selective_repeat_receive_window
   import srrw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire seq_type     req_seq_num,
   input  wire tag_type     req_payload_tag,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output kind_type         rsp_kind,
   output seq_type          rsp_seq_out,
   output tag_type          rsp_tag_out,
   output seq_type          rsp_cumulative_ack,
   output cnt_type          rsp_nack_count,
   output seq_type          rsp_resp_seq,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire csr_idx_type csr_index,
   input  wire cfg_type     csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer
   srrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Window storage, scanner and output register
   srrw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_seq_num        (req_seq_num),
      .req_payload_tag    (req_payload_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_seq_out        (rsp_seq_out),
      .rsp_tag_out        (rsp_tag_out),
      .rsp_cumulative_ack (rsp_cumulative_ack),
      .rsp_nack_count     (rsp_nack_count),
      .rsp_resp_seq       (rsp_resp_seq),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

endmodule

`default_nettype wire

FILE: design/srrw_ctrl.sv
// Sequencing controller of the receive window.
// Depends on srrw_pkg; drives srrw_datapath through command/status structs.
`default_nettype none

module srrw_ctrl
   import srrw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (status.action)
               ACT_START, ACT_FINISH: state_in = S_EMIT_SIMPLE;
               ACT_TICK: begin
                  if (!status.in_progress) begin
                     state_in = S_IDLE;
                  end else begin
                     case (status.last_kind)
                        RK_ACK:  state_in = S_ACK_INIT;
                        default: state_in = S_EMIT_SIMPLE;
                     endcase
                  end
               end
               ACT_DATA: begin
                  if (!status.item_ok) state_in = S_IDLE;
                  else if (status.at_start) state_in = S_DRAIN_RD;
                  else state_in = S_POST_DATA;
               end
            endcase
         end
         S_EMIT_SIMPLE: begin
            if (status.out_free) state_in = S_IDLE;
         end
         S_DRAIN_RD: state_in = S_DRAIN_OUT;
         S_DRAIN_OUT: begin
            if (status.out_free) begin
               state_in = status.next_used ? S_DRAIN_RD : S_POST_DATA;
            end
         end
         S_POST_DATA: state_in = status.send ? S_ACK_INIT : S_IDLE;
         S_ACK_INIT:  state_in = S_ACK_COUNT;
         S_ACK_COUNT: begin
            if (status.scan_done) state_in = S_ACK_HDR;
         end
         S_ACK_HDR: begin
            if (status.out_free) state_in = status.cnt_zero ? S_IDLE : S_ACK_NACK;
         end
         S_ACK_NACK: begin
            if (status.scan_miss && status.out_free && status.remaining_one) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_DECODE: begin
            unique case (status.action)
               ACT_START:  cmd.do_start  = 1'b1;
               ACT_FINISH: cmd.do_finish = 1'b1;
               ACT_TICK:   cmd.do_tick   = 1'b1;
               ACT_DATA:   cmd.do_store  = status.item_ok;
            endcase
         end
         S_EMIT_SIMPLE: cmd.emit_simple = status.out_free;
         S_DRAIN_RD:    cmd.tag_rd      = 1'b1;
         S_DRAIN_OUT:   cmd.deliver     = status.out_free;
         S_POST_DATA:   cmd.post_data   = 1'b1;
         S_ACK_INIT:    cmd.scan_init   = 1'b1;
         S_ACK_COUNT:   cmd.scan_count  = !status.scan_done;
         S_ACK_HDR:     cmd.emit_hdr    = status.out_free;
         S_ACK_NACK:    cmd.scan_nack   = !status.scan_miss || status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/srrw_datapath.sv
// Datapath of the receive window: slot store, window pointers, burst logic,
// nack scanner and the result register. Depends on srrw_pkg and the macros.
`default_nettype none

`include "selective_repeat_receive_window_macros.svh"

module srrw_datapath
   import srrw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status,
   input  wire logic [1:0]    req_action,
   input  wire seq_type       req_seq_num,
   input  wire tag_type       req_payload_tag,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output kind_type           rsp_kind,
   output seq_type            rsp_seq_out,
   output tag_type            rsp_tag_out,
   output seq_type            rsp_cumulative_ack,
   output cnt_type            rsp_nack_count,
   output seq_type            rsp_resp_seq,
   output logic               rsp_last,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire csr_idx_type   csr_index,
   input  wire cfg_type       csr_data
);

   // Latched item
   action_type item_action_ff, item_action_in;
   seq_type    item_seq_ff, item_seq_in;
   tag_type    item_tag_ff, item_tag_in;

   // Configuration
   cfg_type burst_size_ff, burst_size_in;
   cfg_type burst_ticks_ff, burst_ticks_in;

   // Window state
   logic [WINDOW-1:0] used_ff, used_in;
   tag_type           tag_mem [WINDOW];
   tag_type           tag_rd_ff;
   seq_type           window_start_ff, window_start_in;
   seq_type           ack_seq_ff, ack_seq_in;
   seq_type           highest_ff, highest_in;
   logic              in_progress_ff, in_progress_in;
   cfg_type           burst_count_ff, burst_count_in;
   cfg_type           ticks_ff, ticks_in;
   resp_kind_type     last_kind_ff, last_kind_in;
   seq_type           last_seq_ff, last_seq_in;
   logic              drained_ff, drained_in;
   logic              slide_ff, slide_in;

   // Nack scanner
   idx_type scan_idx_ff, scan_idx_in;
   seq_type scan_seq_ff, scan_seq_in;
   cnt_type cnt_ff, cnt_in;
   cnt_type remaining_ff, remaining_in;

   // Result register
   logic     rsp_valid_ff, rsp_valid_in;
   kind_type rsp_kind_ff, rsp_kind_in;
   seq_type  rsp_seq_ff, rsp_seq_in;
   tag_type  rsp_tag_ff, rsp_tag_in;
   seq_type  rsp_cum_ff, rsp_cum_in;
   cnt_type  rsp_cnt_ff, rsp_cnt_in;
   seq_type  rsp_resp_ff, rsp_resp_in;
   logic     rsp_last_ff, rsp_last_in;

   // Derived values
   seq_type seq_off;
   seq_type high_off;
   idx_type item_idx;
   idx_type start_idx;
   idx_type next_idx;
   idx_type scan_total;
   logic    in_window;
   logic    next_used;
   logic    send;
   logic    scan_miss;
   logic    out_free;
   logic    emit_any;

   assign csr_ready = 1'b1;

   // Window arithmetic, all modulo the sequence space
   always_comb begin
      seq_off    = item_seq_ff - window_start_ff;
      high_off   = highest_ff - window_start_ff;
      item_idx   = item_seq_ff[IDX_W-1:0];
      start_idx  = window_start_ff[IDX_W-1:0];
      next_idx   = start_idx + IDX_W'(1);
      in_window  = seq_off < SEQ_W'(WINDOW);
      next_used  = used_ff[next_idx];
      send       = (burst_count_ff == burst_size_ff) || (ticks_ff > burst_ticks_ff);
      scan_total = (high_off > SEQ_W'(WINDOW - 1)) ? IDX_W'(WINDOW - 1)
                                                   : high_off[IDX_W-1:0];
      scan_miss  = !used_ff[scan_seq_ff[IDX_W-1:0]];
      out_free   = !rsp_valid_ff || rsp_ready;
      emit_any   = cmd.emit_simple || cmd.deliver || cmd.emit_hdr ||
                   (cmd.scan_nack && scan_miss);
   end

   // Status to the controller
   always_comb begin
      status.action        = item_action_ff;
      status.item_ok       = in_window && !used_ff[item_idx];
      status.at_start      = item_seq_ff == window_start_ff;
      status.next_used     = next_used;
      status.send          = send;
      status.in_progress   = in_progress_ff;
      status.last_kind     = last_kind_ff;
      status.scan_done     = scan_idx_ff == scan_total;
      status.scan_miss     = scan_miss;
      status.cnt_zero      = cnt_ff == '0;
      status.remaining_one = remaining_ff == CNT_W'(1);
      status.out_free      = out_free;
   end

   // Configuration writes
   always_comb begin
      burst_size_in  = burst_size_ff;
      burst_ticks_in = burst_ticks_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BURST_SIZE:  burst_size_in  = csr_data;
            CSR_BURST_TICKS: burst_ticks_in = csr_data;
         endcase
      end
   end

   // Item latch
   always_comb begin
      item_action_in = item_action_ff;
      item_seq_in    = item_seq_ff;
      item_tag_in    = item_tag_ff;
      if (cmd.load_item) begin
         item_action_in = action_type'(req_action);
         item_seq_in    = req_seq_num;
         item_tag_in    = req_payload_tag;
      end
   end

   // Window and protocol state updates
   always_comb begin
      used_in         = used_ff;
      window_start_in = window_start_ff;
      ack_seq_in      = ack_seq_ff;
      highest_in      = highest_ff;
      in_progress_in  = in_progress_ff;
      burst_count_in  = burst_count_ff;
      ticks_in        = ticks_ff;
      last_kind_in    = last_kind_ff;
      last_seq_in     = last_seq_ff;
      drained_in      = drained_ff;
      slide_in        = slide_ff;

      if (cmd.do_start) begin
         used_in         = '0;
         window_start_in = '0;
         ack_seq_in      = SEQ_W'(SEQ_MODULUS - 1);
         highest_in      = '0;
         ticks_in        = '0;
         in_progress_in  = 1'b1;
         last_kind_in    = RK_READY;
         last_seq_in     = '0;
      end
      if (cmd.do_finish) begin
         in_progress_in = 1'b0;
         last_kind_in   = RK_FINISHED;
         last_seq_in    = '0;
      end
      // saturating tick count
      if (cmd.do_tick && (ticks_ff != '1)) begin
         ticks_in = ticks_ff + CFG_W'(1);
      end
      if (cmd.do_store) begin
         used_in[item_idx] = 1'b1;
         drained_in        = item_seq_ff == window_start_ff;
         slide_in          = 1'b0;
      end
      // in-order delivery advances the window
      if (cmd.deliver) begin
         used_in[start_idx] = 1'b0;
         ack_seq_in         = window_start_ff;
         window_start_in    = window_start_ff + SEQ_W'(1);
         if (window_start_ff == highest_ff) slide_in = 1'b1;
      end
      if (cmd.post_data) begin
         if (drained_ff) begin
            if (slide_ff) highest_in = window_start_ff;
         end else if (seq_off > high_off) begin
            highest_in = item_seq_ff;
         end
         last_kind_in   = RK_ACK;
         last_seq_in    = item_seq_ff;
         burst_count_in = send ? CFG_W'(1) : burst_count_ff + CFG_W'(1);
         if (send) ticks_in = '0;
      end
   end

   // Nack scanner: a counting pass, then an emitting pass
   always_comb begin
      scan_idx_in  = scan_idx_ff;
      scan_seq_in  = scan_seq_ff;
      cnt_in       = cnt_ff;
      remaining_in = remaining_ff;
      if (cmd.scan_init) begin
         scan_idx_in = '0;
         scan_seq_in = window_start_ff;
         cnt_in      = '0;
      end
      if (cmd.scan_count) begin
         if (scan_miss) cnt_in = cnt_ff + CNT_W'(1);
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         scan_seq_in = scan_seq_ff + SEQ_W'(1);
      end
      if (cmd.emit_hdr) begin
         scan_idx_in  = '0;
         scan_seq_in  = window_start_ff;
         remaining_in = cnt_ff;
      end
      if (cmd.scan_nack) begin
         if (scan_miss) remaining_in = remaining_ff - CNT_W'(1);
         scan_seq_in = scan_seq_ff + SEQ_W'(1);
      end
   end

   // Result word; unused fields stay zero
   always_comb begin
      rsp_kind_in = rsp_kind_ff;
      rsp_seq_in  = rsp_seq_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_cum_in  = rsp_cum_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_resp_in = rsp_resp_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_any) begin
         rsp_valid_in = 1'b1;
         rsp_seq_in   = '0;
         rsp_tag_in   = '0;
         rsp_cum_in   = '0;
         rsp_cnt_in   = '0;
         rsp_resp_in  = '0;
         rsp_last_in  = 1'b0;
         rsp_kind_in  = KIND_READY;
         if (cmd.emit_simple) begin
            rsp_kind_in = (last_kind_ff == RK_FINISHED) ? KIND_FINISHED : KIND_READY;
            rsp_last_in = 1'b1;
         end
         if (cmd.deliver) begin
            rsp_kind_in = KIND_DELIVERY;
            rsp_seq_in  = window_start_ff;
            rsp_tag_in  = tag_rd_ff;
            rsp_last_in = !next_used && !send;
         end
         if (cmd.emit_hdr) begin
            rsp_kind_in = KIND_ACK_HDR;
            rsp_cum_in  = ack_seq_ff;
            rsp_cnt_in  = cnt_ff;
            rsp_resp_in = last_seq_ff;
            rsp_last_in = cnt_ff == '0;
         end
         if (cmd.scan_nack) begin
            rsp_kind_in = KIND_NACK;
            rsp_seq_in  = scan_seq_ff;
            rsp_last_in = remaining_ff == CNT_W'(1);
         end
      end
   end

   // Slot tag memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.do_store) tag_mem[item_idx] <= item_tag_ff;
      if (cmd.tag_rd) tag_rd_ff <= tag_mem[start_idx];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_size_ff   <= BURST_SIZE_RST;
         burst_ticks_ff  <= BURST_TICKS_RST;
         used_ff         <= '0;
         window_start_ff <= '0;
         ack_seq_ff      <= SEQ_W'(SEQ_MODULUS - 1);
         highest_ff      <= '0;
         in_progress_ff  <= 1'b0;
         burst_count_ff  <= CFG_W'(1);
         ticks_ff        <= '0;
         last_kind_ff    <= RK_READY;
         last_seq_ff     <= '0;
         drained_ff      <= 1'b0;
         slide_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         burst_size_ff   <= burst_size_in;
         burst_ticks_ff  <= burst_ticks_in;
         used_ff         <= used_in;
         window_start_ff <= window_start_in;
         ack_seq_ff      <= ack_seq_in;
         highest_ff      <= highest_in;
         in_progress_ff  <= in_progress_in;
         burst_count_ff  <= burst_count_in;
         ticks_ff        <= ticks_in;
         last_kind_ff    <= last_kind_in;
         last_seq_ff     <= last_seq_in;
         drained_ff      <= drained_in;
         slide_ff        <= slide_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_action_ff <= item_action_in;
      item_seq_ff    <= item_seq_in;
      item_tag_ff    <= item_tag_in;
      scan_idx_ff    <= scan_idx_in;
      scan_seq_ff    <= scan_seq_in;
      cnt_ff         <= cnt_in;
      remaining_ff   <= remaining_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_seq_ff     <= rsp_seq_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_cum_ff     <= rsp_cum_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_resp_ff    <= rsp_resp_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_seq_out        = rsp_seq_ff;
   assign rsp_tag_out        = rsp_tag_ff;
   assign rsp_cumulative_ack = rsp_cum_ff;
   assign rsp_nack_count     = rsp_cnt_ff;
   assign rsp_resp_seq       = rsp_resp_ff;
   assign rsp_last           = rsp_last_ff;

   // Checks
   `SRRW_ASSERT_SAME(a_emit_into_free, clock, reset, emit_any, out_free, "word emitted over a pending word")
   `SRRW_ASSERT_NEXT(a_start_clears, clock, reset, cmd.do_start, (window_start_ff == '0) && (used_ff == '0) && in_progress_ff, "start did not reset window")
   `SRRW_ASSERT_NEXT(a_deliver_advances, clock, reset, cmd.deliver, window_start_ff == $past(window_start_ff) + SEQ_W'(1), "delivery did not advance window")
   `SRRW_ASSERT_SAME(a_hdr_kind, clock, reset, cmd.emit_hdr, last_kind_ff == RK_ACK, "ack header built without ack pending")

endmodule

`default_nettype wire
